/* rtl/core/rc4fb_pkg.sv */
// Shared types and constants for the RC4 feedback stream cipher unit.
`default_nettype none

package rc4fb_pkg;

    localparam int BYTE_W      = 8;
    localparam int KEY_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCRYPT_MODE = 2'd2;

    // Key bytes repeat every sixteen table positions.
    localparam logic [3:0] KEY_SEL_MASK = 4'hF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_K_RN,
        ST_K_RA,
        ST_K_W1,
        ST_K_W2,
        ST_STEP_I,
        ST_RJ,
        ST_W1,
        ST_W2,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FILL,
        OP_K_RN,
        OP_K_RA,
        OP_K_W1,
        OP_K_W2,
        OP_STEP_I,
        OP_RJ,
        OP_W1,
        OP_W2,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accept;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic out_free;
        logic last_flag;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/rc4_feedback_stream_cipher_unit.sv */
// Top level of the RC4 feedback stream cipher unit.
`default_nettype none

// Byte-stream cipher built on the RC4 key schedule with a ciphertext-feedback
// generator. Each accepted item is one data byte plus a last flag, and each item
// produces exactly one result item carrying the transformed byte and a copy of the
// flag. The permutation lives in a single 256 x 8 memory with one write port and
// one registered read port, and that port sets the pace: each byte steps through
// fetch S[i], fetch S[j], write S[i], write S[j] while fetching S[k], then register
// the result once the output register is free, and the next item is taken in the
// same cycle that the result is registered. The first byte of every message, and
// the first byte after reset, additionally runs the key schedule before its own
// step: a sweep that writes the identity permutation, then 256 key-schedule swaps,
// then a refetch of S[i]. The key and mode registers are written through the
// configuration port, which is always ready; write them only while no item is in
// flight. A key change takes effect at the next schedule, that is after a byte
// flagged last or after reset. The mode register is read when each byte finishes.
module rc4_feedback_stream_cipher_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [rc4fb_pkg::BYTE_W-1:0]        data_byte,
    input  wire logic                                last_byte,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [rc4fb_pkg::BYTE_W-1:0]        out_byte,
    output logic                                     out_last,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rc4fb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rc4fb_pkg::KEY_W-1:0]         cfg_data
);

    rc4fb_pkg::dp_cmd_t    cmd;
    rc4fb_pkg::dp_status_t status;

    // Register writes are taken as soon as they are offered, so the port never pushes back.
    assign cfg_ready = 1'b1;

    rc4fb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rc4fb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

`default_nettype wire

/* rtl/core/rc4fb_dp.sv */
// Datapath: permutation memory, index registers, key and mode registers, output register.
`default_nettype none

module rc4fb_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire rc4fb_pkg::dp_cmd_t                  cmd,
    output rc4fb_pkg::dp_status_t                    status,
    input  wire logic                                cfg_write,
    input  wire logic [rc4fb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rc4fb_pkg::KEY_W-1:0]         cfg_data,
    input  wire logic [rc4fb_pkg::BYTE_W-1:0]        data_byte,
    input  wire logic                                last_byte,
    output logic      [rc4fb_pkg::BYTE_W-1:0]        out_byte,
    output logic                                     out_last,
    output logic                                     out_valid,
    input  wire logic                                out_stall
);

    logic [rc4fb_pkg::BYTE_W-1:0] perm_mem [rc4fb_pkg::TABLE_DEPTH];

    logic [rc4fb_pkg::KEY_W-1:0]  key_low_reg;
    logic [rc4fb_pkg::KEY_W-1:0]  key_high_reg;
    logic                         mode_reg;

    logic [rc4fb_pkg::ADDR_W-1:0] cnt_reg;
    logic [rc4fb_pkg::ADDR_W-1:0] i_reg;
    logic [rc4fb_pkg::ADDR_W-1:0] j_reg;
    logic [rc4fb_pkg::ADDR_W-1:0] k_reg;
    logic [rc4fb_pkg::ADDR_W-1:0] acc_reg;
    logic [rc4fb_pkg::BYTE_W-1:0] p_reg;
    logic [rc4fb_pkg::BYTE_W-1:0] sn_reg;
    logic [rc4fb_pkg::BYTE_W-1:0] data_reg;
    logic                         last_reg;
    logic                         fwd_reg;
    logic [rc4fb_pkg::BYTE_W-1:0] rd_data_reg;

    logic [rc4fb_pkg::BYTE_W-1:0] out_byte_reg;
    logic                         out_last_reg;
    logic                         out_valid_reg;

    logic                         rd_en;
    logic [rc4fb_pkg::ADDR_W-1:0] rd_addr;
    logic                         wr_en;
    logic [rc4fb_pkg::ADDR_W-1:0] wr_addr;
    logic [rc4fb_pkg::BYTE_W-1:0] wr_data;

    logic [rc4fb_pkg::ADDR_W-1:0] i_inc;
    logic [rc4fb_pkg::BYTE_W-1:0] key_sel;
    logic [rc4fb_pkg::ADDR_W-1:0] acc_next;
    logic [rc4fb_pkg::BYTE_W-1:0] p_next;
    logic [rc4fb_pkg::ADDR_W-1:0] j_next;
    logic [rc4fb_pkg::BYTE_W-1:0] ks;
    logic [rc4fb_pkg::BYTE_W-1:0] result;

    // Key byte for the current schedule position.
    always_comb
    begin
        logic [3:0]                 sel;
        logic [rc4fb_pkg::KEY_W-1:0] word;
        sel     = cnt_reg[3:0] & rc4fb_pkg::KEY_SEL_MASK;
        word    = sel[3] ? key_high_reg : key_low_reg;
        key_sel = word[sel[2:0]*rc4fb_pkg::BYTE_W +: rc4fb_pkg::BYTE_W];
    end

    assign i_inc    = i_reg + 1'b1;
    assign acc_next = acc_reg + key_sel + rd_data_reg;
    assign p_next   = p_reg + rd_data_reg;
    assign j_next   = j_reg + p_next;
    // When S[k] was read from the entry that S[j] was written to in the same cycle, take p directly.
    assign ks       = fwd_reg ? p_reg : rd_data_reg;
    assign result   = ks ^ data_reg;

    // Memory port control.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = i_inc;
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = rd_data_reg;
        unique case (cmd.op)
            rc4fb_pkg::OP_FILL:
            begin
                wr_en   = 1'b1;
                wr_data = cnt_reg;
            end
            rc4fb_pkg::OP_K_RN:
            begin
                rd_en   = 1'b1;
                rd_addr = cnt_reg;
            end
            rc4fb_pkg::OP_K_RA:
            begin
                rd_en   = 1'b1;
                rd_addr = acc_next;
            end
            rc4fb_pkg::OP_K_W1:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = rd_data_reg;
            end
            rc4fb_pkg::OP_K_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = acc_reg;
                wr_data = sn_reg;
            end
            rc4fb_pkg::OP_STEP_I:
            begin
                rd_en   = 1'b1;
                rd_addr = i_inc;
            end
            rc4fb_pkg::OP_RJ:
            begin
                rd_en   = 1'b1;
                rd_addr = j_next;
            end
            rc4fb_pkg::OP_W1:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = rd_data_reg;
            end
            rc4fb_pkg::OP_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = p_reg;
                rd_en   = 1'b1;
                rd_addr = k_reg;
            end
            default:
            begin
            end
        endcase
        // An accepted item starts by fetching S[i+1]; it only pairs with ops that leave
        // the read port free.
        if (cmd.accept)
        begin
            rd_en   = 1'b1;
            rd_addr = i_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            perm_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= perm_mem[rd_addr];
        end
    end

    // Index and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (cmd.accept || cmd.op == rc4fb_pkg::OP_STEP_I)
        begin
            i_reg <= i_inc;
        end
        unique case (cmd.op)
            rc4fb_pkg::OP_FILL:
            begin
                i_reg   <= '0;
                j_reg   <= '0;
                p_reg   <= '0;
                acc_reg <= '0;
            end
            rc4fb_pkg::OP_K_RA:
            begin
                acc_reg <= acc_next;
                sn_reg  <= rd_data_reg;
            end
            rc4fb_pkg::OP_RJ:
            begin
                p_reg <= p_next;
                j_reg <= j_next;
            end
            rc4fb_pkg::OP_W1:
            begin
                k_reg <= rd_data_reg + p_reg;
            end
            rc4fb_pkg::OP_W2:
            begin
                fwd_reg <= (k_reg == j_reg);
            end
            rc4fb_pkg::OP_OUT:
            begin
                p_reg        <= mode_reg ? result : data_reg;
                out_byte_reg <= result;
                out_last_reg <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Schedule counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == rc4fb_pkg::OP_FILL || cmd.op == rc4fb_pkg::OP_K_W2)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.op == rc4fb_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            mode_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rc4fb_pkg::CFG_KEY_LOW:      key_low_reg  <= cfg_data;
                rc4fb_pkg::CFG_KEY_HIGH:     key_high_reg <= cfg_data;
                rc4fb_pkg::CFG_ENCRYPT_MODE: mode_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign status.cnt_last  = (cnt_reg == rc4fb_pkg::ADDR_W'(rc4fb_pkg::TABLE_DEPTH - 1));
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.last_flag = last_reg;

    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

    // The output register is loaded only when its previous item is gone.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == rc4fb_pkg::OP_OUT |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while holding an item");

    // Every identity fill sweep begins at entry zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == rc4fb_pkg::OP_FILL && $past(cmd.op) != rc4fb_pkg::OP_FILL)
        |-> cnt_reg == '0)
        else $error("fill sweep started at a nonzero entry");

    // The read port never carries two requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (cmd.op == rc4fb_pkg::OP_NONE || cmd.op == rc4fb_pkg::OP_OUT))
        else $error("accept collided with a memory read");

endmodule

`default_nettype wire

/* rtl/core/rc4fb_ctrl.sv */
// Controller state machine: sequences key schedule and per-byte generator steps.
`default_nettype none

module rc4fb_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire rc4fb_pkg::dp_status_t    status,
    output rc4fb_pkg::dp_cmd_t            cmd
);

    rc4fb_pkg::ctrl_state_t state_reg;
    rc4fb_pkg::ctrl_state_t state_next;
    logic                   need_sched_reg;
    logic                   need_sched_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rc4fb_pkg::ST_IDLE;
            need_sched_reg <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            need_sched_reg <= need_sched_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        need_sched_next = need_sched_reg;
        cmd.op          = rc4fb_pkg::OP_NONE;
        cmd.accept      = 1'b0;
        in_stall        = 1'b1;
        unique case (state_reg)
            rc4fb_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = need_sched_reg ? rc4fb_pkg::ST_FILL : rc4fb_pkg::ST_RJ;
                end
            end
            rc4fb_pkg::ST_FILL:
            begin
                cmd.op = rc4fb_pkg::OP_FILL;
                if (status.cnt_last)
                begin
                    state_next = rc4fb_pkg::ST_K_RN;
                end
            end
            rc4fb_pkg::ST_K_RN:
            begin
                cmd.op     = rc4fb_pkg::OP_K_RN;
                state_next = rc4fb_pkg::ST_K_RA;
            end
            rc4fb_pkg::ST_K_RA:
            begin
                cmd.op     = rc4fb_pkg::OP_K_RA;
                state_next = rc4fb_pkg::ST_K_W1;
            end
            rc4fb_pkg::ST_K_W1:
            begin
                cmd.op     = rc4fb_pkg::OP_K_W1;
                state_next = rc4fb_pkg::ST_K_W2;
            end
            rc4fb_pkg::ST_K_W2:
            begin
                cmd.op = rc4fb_pkg::OP_K_W2;
                if (status.cnt_last)
                begin
                    state_next      = rc4fb_pkg::ST_STEP_I;
                    need_sched_next = 1'b0;
                end
                else
                begin
                    state_next = rc4fb_pkg::ST_K_RN;
                end
            end
            rc4fb_pkg::ST_STEP_I:
            begin
                cmd.op     = rc4fb_pkg::OP_STEP_I;
                state_next = rc4fb_pkg::ST_RJ;
            end
            rc4fb_pkg::ST_RJ:
            begin
                cmd.op     = rc4fb_pkg::OP_RJ;
                state_next = rc4fb_pkg::ST_W1;
            end
            rc4fb_pkg::ST_W1:
            begin
                cmd.op     = rc4fb_pkg::OP_W1;
                state_next = rc4fb_pkg::ST_W2;
            end
            rc4fb_pkg::ST_W2:
            begin
                cmd.op     = rc4fb_pkg::OP_W2;
                state_next = rc4fb_pkg::ST_OUT;
            end
            rc4fb_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = rc4fb_pkg::OP_OUT;
                    in_stall   = 1'b0;
                    cmd.accept = in_valid;
                    if (status.last_flag)
                    begin
                        need_sched_next = 1'b1;
                    end
                    if (in_valid)
                    begin
                        state_next = (need_sched_reg || status.last_flag) ?
                                     rc4fb_pkg::ST_FILL : rc4fb_pkg::ST_RJ;
                    end
                    else
                    begin
                        state_next = rc4fb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rc4fb_pkg::ST_IDLE;
            end
        endcase
    end

    // A message's first byte arriving in idle always triggers the identity fill.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4fb_pkg::ST_IDLE && in_valid && need_sched_reg)
        |=> state_reg == rc4fb_pkg::ST_FILL)
        else $error("schedule skipped for a new message");

    // The schedule request clears only when the last swap of the key schedule is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(need_sched_reg) |-> $past(state_reg) == rc4fb_pkg::ST_K_W2)
        else $error("schedule request cleared early");

    // A finished byte waits while the output register is still occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4fb_pkg::ST_OUT && !status.out_free)
        |=> state_reg == rc4fb_pkg::ST_OUT)
        else $error("result step left while output blocked");

endmodule

`default_nettype wire
